### rtl/core/mbsoc_pkg.sv
// ----------------------------------------------------------------------------
// Multi-battery SoC combiner package
// Field widths, bus layout, register indexes, codes and shared helpers.
// ----------------------------------------------------------------------------
package mbsoc_pkg;

    localparam int SOC_W     = 7;
    localparam int SOC_IN_W  = 8;
    localparam int MV_W      = 16;
    localparam int TIME_W    = 32;
    localparam int DEV_W     = 3;
    localparam int MASK_W    = 8;
    localparam int MODE_W    = 3;
    localparam int LOCK_W    = 16;
    localparam int PHASE_W   = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // average accumulator: up to nine entries of at most 100 each
    localparam int SUM_W = 10;
    localparam int CNT_W = 4;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    // s_tdata layout
    localparam int DEVICE_LSB = 0;
    localparam int SOC_IN_LSB = DEVICE_LSB + DEV_W;
    localparam int NOW_LSB    = SOC_IN_LSB + SOC_IN_W;
    localparam int FORCE_BIT  = NOW_LSB + TIME_W;
    localparam int MV_LSB     = FORCE_BIT + 1;
    localparam int S_USED_W   = MV_LSB + MV_W;

    // m_tdata layout
    localparam int SOC_OUT_LSB = 0;
    localparam int PHASE_LSB   = SOC_OUT_LSB + SOC_W;
    localparam int M_USED_W    = PHASE_LSB + PHASE_W;

    localparam logic [SOC_W-1:0] FULL_SOC = 7'd100;

    localparam logic ACT_REPORT  = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_PRIMARY = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AVG     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MAX     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIN     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIRST   = 3'd4;

    localparam logic [PHASE_W-1:0] PHASE_WAIT     = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_OVERRIDE = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_LOCK     = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_STRAY    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_INDEX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CELL_EN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_MV      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_MV        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_SOC  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_TICKS    = 3'd7;

    // one table lookup
    typedef struct packed {
        logic             fresh;
        logic [SOC_W-1:0] soc;
    } entry_rd_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    // clamp a charge percentage to 100
    function automatic logic [SOC_W-1:0] clamp_soc(input logic [SOC_IN_W-1:0] v);
        if (v > {1'b0, FULL_SOC}) begin
            return FULL_SOC;
        end
        return v[SOC_W-1:0];
    endfunction

endpackage

### rtl/core/multi_battery_soc_combiner_core.sv
// ----------------------------------------------------------------------------
// Multi-battery state-of-charge combiner core
// Tracks per-battery charge reports and produces one combined charge value,
// with a low-cell-voltage override, for every compute transaction.
// ----------------------------------------------------------------------------
// A report transaction (s_tuser = 0) stores the battery's charge, clamped to
// 100, with its timestamp, and produces nothing. A compute transaction
// (s_tuser = 1) produces exactly one output transaction. The core handles
// one transaction at a time: s_tready is high only while the sequencer is
// idle. A compute walks the battery table through one freshness comparator
// (a 32-bit wrap-around age check), one entry per cycle: the primary battery
// first, then all eight table slots when a combine mode with a non-zero mask
// is set. Averaging then runs a restoring divide when any battery counted.
// With the low-cell update and the output load, a compute holds s_tready low
// until its result is loaded onto m_tvalid, which waits while the output
// register still holds an untaken result. The output register lets the last
// result wait while the next transaction is accepted. Configuration must be
// written through cfg_wr_en/cfg_index/cfg_wdata only while the core is
// idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module multi_battery_soc_combiner_core #(
    parameter int NUM_DEVICES = 8,
    parameter int TIMEOUT_MS  = 5000
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [mbsoc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbsoc_pkg::CFG_W-1:0]          cfg_wdata,

    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: device[2:0], soc_in[10:3], now_ms[42:11], force_full[43],
    //        min_cell_mv[59:44], zero fill[63:60]
    input  logic [mbsoc_pkg::S_TDATA_W-1:0]      s_tdata,
    // tuser: action (0 report, 1 compute)
    input  logic                                 s_tuser,

    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: soc_out[6:0], low_cell_phase[8:7], zero fill[15:9]
    output logic [mbsoc_pkg::M_TDATA_W-1:0]      m_tdata
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_PRIM      = 7'b0000010,
        ST_SCAN      = 7'b0000100,
        ST_DIV_START = 7'b0001000,
        ST_DIV_WAIT  = 7'b0010000,
        ST_LOW       = 7'b0100000,
        ST_OUT       = 7'b1000000
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [mbsoc_pkg::MODE_W-1:0]  combine_mode_reg;
    logic [mbsoc_pkg::MASK_W-1:0]  select_mask_reg;
    logic [mbsoc_pkg::DEV_W-1:0]   primary_index_reg;
    logic                          low_cell_enable_reg;
    logic [mbsoc_pkg::MV_W-1:0]    start_mv_reg;
    logic [mbsoc_pkg::MV_W-1:0]    end_mv_reg;
    logic [mbsoc_pkg::SOC_W-1:0]   override_soc_reg;
    logic [mbsoc_pkg::LOCK_W-1:0]  lock_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            combine_mode_reg    <= '0;
            select_mask_reg     <= '0;
            primary_index_reg   <= '0;
            low_cell_enable_reg <= 1'b0;
            start_mv_reg        <= '0;
            end_mv_reg          <= '0;
            override_soc_reg    <= '0;
            lock_ticks_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mbsoc_pkg::REG_COMBINE_MODE:
                    combine_mode_reg <= cfg_wdata[mbsoc_pkg::MODE_W-1:0];
                mbsoc_pkg::REG_SELECT_MASK:
                    select_mask_reg <= cfg_wdata[mbsoc_pkg::MASK_W-1:0];
                mbsoc_pkg::REG_PRIMARY_INDEX:
                    primary_index_reg <= cfg_wdata[mbsoc_pkg::DEV_W-1:0];
                mbsoc_pkg::REG_LOW_CELL_EN:
                    low_cell_enable_reg <= cfg_wdata[0];
                mbsoc_pkg::REG_START_MV:
                    start_mv_reg <= cfg_wdata[mbsoc_pkg::MV_W-1:0];
                mbsoc_pkg::REG_END_MV:
                    end_mv_reg <= cfg_wdata[mbsoc_pkg::MV_W-1:0];
                mbsoc_pkg::REG_OVERRIDE_SOC:
                    override_soc_reg <= cfg_wdata[mbsoc_pkg::SOC_W-1:0];
                mbsoc_pkg::REG_LOCK_TICKS:
                    lock_ticks_reg <= cfg_wdata[mbsoc_pkg::LOCK_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and working registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [mbsoc_pkg::TIME_W-1:0]  now_reg, now_next;
    logic                          force_reg, force_next;
    logic [mbsoc_pkg::MV_W-1:0]    mv_reg, mv_next;
    logic [mbsoc_pkg::SOC_W-1:0]   res_reg, res_next;
    logic [mbsoc_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [mbsoc_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                          first_done_reg, first_done_next;
    logic [mbsoc_pkg::DEV_W-1:0]   scan_idx_reg, scan_idx_next;

    logic [mbsoc_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [mbsoc_pkg::LOCK_W-1:0]  lock_count_reg, lock_count_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [mbsoc_pkg::SOC_W-1:0]   out_soc_reg, out_soc_next;
    logic [mbsoc_pkg::PHASE_W-1:0] out_phase_reg, out_phase_next;

    // ------------------------------------------------------------------
    // Shared table lookup and divider
    // ------------------------------------------------------------------
    logic                          s_accept;
    logic                          report_wr;
    logic [mbsoc_pkg::DEV_W-1:0]   rd_dev;
    mbsoc_pkg::entry_rd_t          entry;
    mbsoc_pkg::div_req_t           div_req;
    mbsoc_pkg::div_rsp_t           div_rsp;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign report_wr = s_accept && (s_tuser == mbsoc_pkg::ACT_REPORT);

    // point the single lookup at the primary first, then walk the mask
    assign rd_dev = (state_reg == ST_PRIM) ? primary_index_reg : scan_idx_reg;

    mbsoc_table #(
        .NUM_DEVICES (NUM_DEVICES),
        .TIMEOUT_MS  (TIMEOUT_MS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (report_wr),
        .wr_dev   (s_tdata[mbsoc_pkg::DEVICE_LSB +: mbsoc_pkg::DEV_W]),
        .wr_soc   (s_tdata[mbsoc_pkg::SOC_IN_LSB +: mbsoc_pkg::SOC_IN_W]),
        .wr_stamp (s_tdata[mbsoc_pkg::NOW_LSB +: mbsoc_pkg::TIME_W]),
        .rd_dev   (rd_dev),
        .now_ms   (now_reg),
        .rd       (entry)
    );

    assign div_req.start    = (state_reg == ST_DIV_START);
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = count_reg;

    mbsoc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // Combine and low-cell logic
    // ------------------------------------------------------------------
    logic                          scan_active;
    logic                          sel_bit;
    logic                          out_free;
    logic [mbsoc_pkg::MV_W-1:0]    end_mv;

    // scan only for modes that look past the primary
    assign scan_active = (select_mask_reg != '0) &&
                         ((combine_mode_reg == mbsoc_pkg::MODE_AVG) ||
                          (combine_mode_reg == mbsoc_pkg::MODE_MAX) ||
                          (combine_mode_reg == mbsoc_pkg::MODE_MIN) ||
                          (combine_mode_reg == mbsoc_pkg::MODE_FIRST));
    assign sel_bit  = select_mask_reg[scan_idx_reg];
    assign out_free = !m_tvalid_reg || m_tready;
    // zero end threshold falls back to the start threshold
    assign end_mv   = (end_mv_reg != '0) ? end_mv_reg : start_mv_reg;

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        force_next      = force_reg;
        mv_next         = mv_reg;
        res_next        = res_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        first_done_next = first_done_reg;
        scan_idx_next   = scan_idx_reg;
        phase_next      = phase_reg;
        lock_count_next = lock_count_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_soc_next    = out_soc_reg;
        out_phase_next  = out_phase_reg;

        // drain the output register whenever the sink takes it
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                // reports are written into the table straight from the bus
                if (s_accept && (s_tuser == mbsoc_pkg::ACT_COMPUTE)) begin
                    now_next   = s_tdata[mbsoc_pkg::NOW_LSB +: mbsoc_pkg::TIME_W];
                    force_next = s_tdata[mbsoc_pkg::FORCE_BIT];
                    mv_next    = s_tdata[mbsoc_pkg::MV_LSB +: mbsoc_pkg::MV_W];
                    state_next = ST_PRIM;
                end
            end

            ST_PRIM: begin
                // seed from the primary, zero when it is stale
                if (entry.fresh) begin
                    res_next   = entry.soc;
                    sum_next   = mbsoc_pkg::SUM_W'(entry.soc);
                    count_next = mbsoc_pkg::CNT_W'(1);
                end else begin
                    res_next   = '0;
                    sum_next   = '0;
                    count_next = '0;
                end
                first_done_next = 1'b0;
                scan_idx_next   = '0;
                state_next      = scan_active ? ST_SCAN : ST_LOW;
            end

            ST_SCAN: begin
                case (combine_mode_reg)
                    mbsoc_pkg::MODE_AVG: begin
                        if (sel_bit && entry.fresh) begin
                            sum_next   = sum_reg + mbsoc_pkg::SUM_W'(entry.soc);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    mbsoc_pkg::MODE_MAX: begin
                        if (sel_bit && entry.fresh && (entry.soc > res_reg)) begin
                            res_next = entry.soc;
                        end
                    end
                    mbsoc_pkg::MODE_MIN: begin
                        if (sel_bit && entry.fresh && (entry.soc < res_reg)) begin
                            res_next = entry.soc;
                        end
                    end
                    mbsoc_pkg::MODE_FIRST: begin
                        // only the lowest selected device counts, fresh or not
                        if (sel_bit && !first_done_reg) begin
                            first_done_next = 1'b1;
                            if (entry.fresh) begin
                                res_next = entry.soc;
                            end
                        end
                    end
                    default: ;
                endcase
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == '1) begin
                    if ((combine_mode_reg == mbsoc_pkg::MODE_AVG) &&
                        (count_next != '0)) begin
                        state_next = ST_DIV_START;
                    end else begin
                        state_next = ST_LOW;
                    end
                end
            end

            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    res_next   = div_rsp.quotient[mbsoc_pkg::SOC_W-1:0];
                    state_next = ST_LOW;
                end
            end

            ST_LOW: begin
                if (force_reg) begin
                    // forced full: leave the override machine alone
                    res_next = mbsoc_pkg::FULL_SOC;
                end else if (!low_cell_enable_reg) begin
                    phase_next = mbsoc_pkg::PHASE_WAIT;
                end else begin
                    case (phase_reg)
                        mbsoc_pkg::PHASE_WAIT: begin
                            if (mv_reg <= start_mv_reg) begin
                                phase_next = mbsoc_pkg::PHASE_OVERRIDE;
                            end
                        end
                        mbsoc_pkg::PHASE_OVERRIDE: begin
                            if (mv_reg > end_mv) begin
                                lock_count_next = lock_ticks_reg;
                                phase_next      = mbsoc_pkg::PHASE_LOCK;
                            end
                            res_next = mbsoc_pkg::clamp_soc({1'b0, override_soc_reg});
                        end
                        mbsoc_pkg::PHASE_LOCK: begin
                            if (lock_count_reg == '0) begin
                                phase_next = mbsoc_pkg::PHASE_WAIT;
                            end else begin
                                lock_count_next = lock_count_reg - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                state_next = ST_OUT;
            end

            ST_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    out_soc_next   = res_reg;
                    out_phase_next = phase_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= mbsoc_pkg::PHASE_WAIT;
            lock_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            lock_count_reg <= lock_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg        <= now_next;
        force_reg      <= force_next;
        mv_reg         <= mv_next;
        res_reg        <= res_next;
        sum_reg        <= sum_next;
        count_reg      <= count_next;
        first_done_reg <= first_done_next;
        scan_idx_reg   <= scan_idx_next;
        out_soc_reg    <= out_soc_next;
        out_phase_reg  <= out_phase_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mbsoc_pkg::M_TDATA_W - mbsoc_pkg::M_USED_W){1'b0}},
                       out_phase_reg, out_soc_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_phase_reachable: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != mbsoc_pkg::PHASE_STRAY)
        else $error("low-cell phase reached the unused code");

    a_soc_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[mbsoc_pkg::SOC_W-1:0] <= mbsoc_pkg::FULL_SOC))
        else $error("output charge above 100 percent");

    a_prim_after_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRIM) |->
            $past(s_accept && (s_tuser == mbsoc_pkg::ACT_COMPUTE)))
        else $error("table walk started without a compute transaction");

    a_lock_only_in_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOW) |=> $stable(lock_count_reg))
        else $error("lockout counter moved outside the low-cell update");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished while the sequencer was not waiting");

endmodule

### rtl/core/mbsoc_table.sv
// ----------------------------------------------------------------------------
// Battery entry table
// Per-device charge and timestamp store with valid bits and a freshness check.
// ----------------------------------------------------------------------------
module mbsoc_table #(
    parameter int NUM_DEVICES = 8,
    parameter int TIMEOUT_MS  = 5000
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [mbsoc_pkg::DEV_W-1:0]    wr_dev,
    input  logic [mbsoc_pkg::SOC_IN_W-1:0] wr_soc,
    input  logic [mbsoc_pkg::TIME_W-1:0]   wr_stamp,
    input  logic [mbsoc_pkg::DEV_W-1:0]    rd_dev,
    input  logic [mbsoc_pkg::TIME_W-1:0]   now_ms,
    output mbsoc_pkg::entry_rd_t           rd
);

    localparam int AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

    logic [mbsoc_pkg::SOC_W-1:0]  soc_table_reg   [NUM_DEVICES];
    logic [mbsoc_pkg::TIME_W-1:0] stamp_table_reg [NUM_DEVICES];
    logic [NUM_DEVICES-1:0]       valid_reg;

    logic [AW+mbsoc_pkg::DEV_W-1:0] wr_wide;
    logic [AW+mbsoc_pkg::DEV_W-1:0] rd_wide;
    logic [AW-1:0]                  wr_addr;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_in_range;
    logic                           rd_in_range;
    logic [mbsoc_pkg::TIME_W-1:0]   age;

    assign wr_wide     = {{AW{1'b0}}, wr_dev};
    assign rd_wide     = {{AW{1'b0}}, rd_dev};
    assign wr_addr     = wr_wide[AW-1:0];
    assign rd_addr     = rd_wide[AW-1:0];
    assign wr_in_range = {29'd0, wr_dev} < NUM_DEVICES;
    assign rd_in_range = {29'd0, rd_dev} < NUM_DEVICES;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en && wr_in_range) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_in_range) begin
            soc_table_reg[wr_addr]   <= mbsoc_pkg::clamp_soc(wr_soc);
            stamp_table_reg[wr_addr] <= wr_stamp;
        end
    end

    // age wraps modulo 2^32
    always_comb begin
        age      = '0;
        rd.soc   = '0;
        rd.fresh = 1'b0;
        if (rd_in_range) begin
            age      = now_ms - stamp_table_reg[rd_addr];
            rd.soc   = soc_table_reg[rd_addr];
            rd.fresh = valid_reg[rd_addr] &&
                       (age < mbsoc_pkg::TIME_W'(TIMEOUT_MS));
        end
    end

endmodule

### rtl/core/mbsoc_div.sv
// ----------------------------------------------------------------------------
// Average divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbsoc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbsoc_pkg::div_req_t req,
    output mbsoc_pkg::div_rsp_t rsp
);

    localparam int STEP_W = $clog2(mbsoc_pkg::SUM_W + 1);

    logic [mbsoc_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [mbsoc_pkg::SUM_W-1:0] quo_reg, quo_next;
    logic [mbsoc_pkg::CNT_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [mbsoc_pkg::CNT_W:0] rem_shift;
    logic [mbsoc_pkg::CNT_W:0] rem_diff;
    logic                      fits;

    assign rem_shift = {rem_reg, quo_reg[mbsoc_pkg::SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            step_next = STEP_W'(mbsoc_pkg::SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? rem_diff[mbsoc_pkg::CNT_W-1:0]
                             : rem_shift[mbsoc_pkg::CNT_W-1:0];
            quo_next  = {quo_reg[mbsoc_pkg::SUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### dv/tb_multi_battery_soc_combiner_core.sv
// ----------------------------------------------------------------------------
// Testbench for multi_battery_soc_combiner_core
// Drives battery report and compute transactions through the input stream and
// checks every combined charge result against a cycle-free predictor. The
// predictor keeps its own copy of the per-battery table and the low-cell state
// machine. A directed prologue covers the corner cases. Several phases of
// random traffic follow, each under its own register settings, with bursty
// input, a stalling result side and one long result back-pressure window.
// ----------------------------------------------------------------------------
module tb_multi_battery_soc_combiner_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DEV         = 8;
    localparam int AGE_LIMIT_MS    = 5000;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 3;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 125;
    // room after the last result for a trailing report to settle
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_AFTER      = 400;
    localparam int HOLD_CYCLES     = 600;
    localparam int CYCLE_LIMIT     = 400000;

    // one input transaction, unpacked
    typedef struct {
        logic                           action;
        logic [mbsoc_pkg::DEV_W-1:0]    device;
        logic [mbsoc_pkg::SOC_IN_W-1:0] soc_in;
        logic [mbsoc_pkg::TIME_W-1:0]   now_ms;
        logic                           force_full;
        logic [mbsoc_pkg::MV_W-1:0]     min_cell_mv;
    } batt_item_t;

    // one result transaction, unpacked
    typedef struct {
        logic [mbsoc_pkg::SOC_W-1:0]   soc;
        logic [mbsoc_pkg::PHASE_W-1:0] phase;
    } soc_result_t;

    // ------------------------------------------------------------------------
    // Charge predictor and result checker
    // ------------------------------------------------------------------------
    class soc_scoreboard;
        // register mirror
        logic [mbsoc_pkg::MODE_W-1:0]  mode;
        logic [mbsoc_pkg::MASK_W-1:0]  mask;
        logic [mbsoc_pkg::DEV_W-1:0]   prim;
        logic                          lc_en;
        logic [mbsoc_pkg::MV_W-1:0]    start_mv;
        logic [mbsoc_pkg::MV_W-1:0]    end_mv;
        logic [mbsoc_pkg::SOC_W-1:0]   ovr_soc;
        logic [mbsoc_pkg::LOCK_W-1:0]  lock_ticks;
        // battery table and low-cell state
        logic [mbsoc_pkg::SOC_W-1:0]   soc_tab[NUM_DEV];
        logic [mbsoc_pkg::TIME_W-1:0]  stamp_tab[NUM_DEV];
        logic [NUM_DEV-1:0]            valid;
        logic [mbsoc_pkg::PHASE_W-1:0] phase;
        logic [mbsoc_pkg::LOCK_W-1:0]  lock_cnt;

        soc_result_t exp_charge_q[$];
        int errors;
        int n_inputs;

        function new();
            mode = '0; mask = '0; prim = '0; lc_en = 1'b0;
            start_mv = '0; end_mv = '0; ovr_soc = '0; lock_ticks = '0;
            foreach (soc_tab[i]) begin
                soc_tab[i] = '0;
                stamp_tab[i] = '0;
            end
            valid = '0;
            phase = mbsoc_pkg::PHASE_WAIT;
            lock_cnt = '0;
            errors = 0;
            n_inputs = 0;
        endfunction

        function void write_reg(logic [mbsoc_pkg::CFG_IDX_W-1:0] idx,
                                logic [mbsoc_pkg::CFG_W-1:0] val);
            case (idx)
                mbsoc_pkg::REG_COMBINE_MODE:  mode = val[mbsoc_pkg::MODE_W-1:0];
                mbsoc_pkg::REG_SELECT_MASK:   mask = val[mbsoc_pkg::MASK_W-1:0];
                mbsoc_pkg::REG_PRIMARY_INDEX: prim = val[mbsoc_pkg::DEV_W-1:0];
                mbsoc_pkg::REG_LOW_CELL_EN:   lc_en = val[0];
                mbsoc_pkg::REG_START_MV:      start_mv = val[mbsoc_pkg::MV_W-1:0];
                mbsoc_pkg::REG_END_MV:        end_mv = val[mbsoc_pkg::MV_W-1:0];
                mbsoc_pkg::REG_OVERRIDE_SOC:  ovr_soc = val[mbsoc_pkg::SOC_W-1:0];
                mbsoc_pkg::REG_LOCK_TICKS:    lock_ticks = val[mbsoc_pkg::LOCK_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [mbsoc_pkg::SOC_W-1:0] sat_pct(logic [mbsoc_pkg::SOC_IN_W-1:0] v);
            return (v > 8'd100) ? 7'd100 : v[mbsoc_pkg::SOC_W-1:0];
        endfunction

        // fresh: written at some point, and younger than the timeout with wrap
        function bit is_fresh(int dev, logic [mbsoc_pkg::TIME_W-1:0] now);
            logic [mbsoc_pkg::TIME_W-1:0] age;
            age = now - stamp_tab[dev];
            return valid[dev] && (age < AGE_LIMIT_MS);
        endfunction

        function logic [mbsoc_pkg::SOC_W-1:0] combine_charge(
                logic [mbsoc_pkg::TIME_W-1:0] now);
            int res;
            int sum;
            int cnt;
            bit taken;
            res = 0;
            sum = 0;
            cnt = 0;
            taken = 1'b0;
            if (is_fresh(int'(prim), now)) begin
                res = int'(soc_tab[prim]);
                sum = res;
                cnt = 1;
            end
            if (mask != '0 && (mode == mbsoc_pkg::MODE_AVG ||
                               mode == mbsoc_pkg::MODE_MAX ||
                               mode == mbsoc_pkg::MODE_MIN)) begin
                for (int i = 0; i < NUM_DEV; i++) begin
                    if (mask[i] && is_fresh(i, now)) begin
                        if (mode == mbsoc_pkg::MODE_AVG) begin
                            sum += int'(soc_tab[i]);
                            cnt++;
                        end else if (mode == mbsoc_pkg::MODE_MAX) begin
                            if (int'(soc_tab[i]) > res) res = int'(soc_tab[i]);
                        end else if (int'(soc_tab[i]) < res) begin
                            res = int'(soc_tab[i]);
                        end
                    end
                end
                if (mode == mbsoc_pkg::MODE_AVG && cnt > 0) res = sum / cnt;
            end else if (mask != '0 && mode == mbsoc_pkg::MODE_FIRST) begin
                // only the lowest selected battery counts; stale keeps the seed
                for (int i = 0; i < NUM_DEV; i++) begin
                    if (mask[i] && !taken) begin
                        taken = 1'b1;
                        if (is_fresh(i, now)) res = int'(soc_tab[i]);
                    end
                end
            end
            return res[mbsoc_pkg::SOC_W-1:0];
        endfunction

        function logic [mbsoc_pkg::SOC_W-1:0] apply_low_cell(
                logic [mbsoc_pkg::SOC_W-1:0] soc, logic [mbsoc_pkg::MV_W-1:0] mv);
            logic [mbsoc_pkg::MV_W-1:0] end_th;
            end_th = (end_mv != '0) ? end_mv : start_mv;
            case (phase)
                mbsoc_pkg::PHASE_WAIT: begin
                    if (mv <= start_mv) phase = mbsoc_pkg::PHASE_OVERRIDE;
                end
                mbsoc_pkg::PHASE_OVERRIDE: begin
                    if (mv > end_th) begin
                        lock_cnt = lock_ticks;
                        phase = mbsoc_pkg::PHASE_LOCK;
                    end
                    soc = sat_pct({1'b0, ovr_soc});
                end
                mbsoc_pkg::PHASE_LOCK: begin
                    if (lock_cnt == '0) phase = mbsoc_pkg::PHASE_WAIT;
                    else lock_cnt = lock_cnt - 1'b1;
                end
                default: ;
            endcase
            return soc;
        endfunction

        function void note_input(batt_item_t it);
            soc_result_t r;
            logic [mbsoc_pkg::SOC_W-1:0] res;
            n_inputs++;
            if (it.action == mbsoc_pkg::ACT_REPORT) begin
                soc_tab[it.device] = sat_pct(it.soc_in);
                stamp_tab[it.device] = it.now_ms;
                valid[it.device] = 1'b1;
                return;
            end
            if (it.force_full) begin
                // state machine frozen, phase reported as is
                res = mbsoc_pkg::FULL_SOC;
            end else begin
                res = combine_charge(it.now_ms);
                if (lc_en) res = apply_low_cell(res, it.min_cell_mv);
                else phase = mbsoc_pkg::PHASE_WAIT;
            end
            r.soc = sat_pct({1'b0, res});
            r.phase = phase;
            exp_charge_q.push_back(r);
        endfunction

        function void check_result(logic [mbsoc_pkg::M_TDATA_W-1:0] data);
            soc_result_t got;
            soc_result_t want;
            got.soc = data[mbsoc_pkg::SOC_OUT_LSB +: mbsoc_pkg::SOC_W];
            got.phase = data[mbsoc_pkg::PHASE_LSB +: mbsoc_pkg::PHASE_W];
            if (exp_charge_q.size() == 0) begin
                $display("%0t: unexpected result: soc_out %0d low_cell_phase %0d",
                         $time, got.soc, got.phase);
                errors++;
                return;
            end
            want = exp_charge_q.pop_front();
            if (got.soc != want.soc) begin
                $display("%0t: soc_out mismatch: expected %0d, actual %0d",
                         $time, want.soc, got.soc);
                errors++;
            end
            if (got.phase != want.phase) begin
                $display("%0t: low_cell_phase mismatch: expected %0d, actual %0d",
                         $time, want.phase, got.phase);
                errors++;
            end
        endfunction

        function int pending();
            return exp_charge_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, clock and block under test
    // ------------------------------------------------------------------------
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [mbsoc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mbsoc_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    // tdata: device, soc_in, now_ms, force_full, min_cell_mv, zero fill
    logic [mbsoc_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    // tuser: action
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // tdata: soc_out, low_cell_phase, zero fill
    logic [mbsoc_pkg::M_TDATA_W-1:0] m_tdata;

    soc_scoreboard sb = new();

    // sender and receiver pacing state
    int                           burst_left = 0;
    logic [mbsoc_pkg::TIME_W-1:0] cur_ms     = '0;
    int                           win_left   = 0;
    int                           ready_pct  = 100;
    int                           hold_left  = 0;
    bit                           hold_done  = 1'b0;
    bit                           rdy_next;
    int                           cycles     = 0;

    always #(CLK_HALF) aclk = ~aclk;

    multi_battery_soc_combiner_core #(
        .NUM_DEVICES (NUM_DEV),
        .TIMEOUT_MS  (AGE_LIMIT_MS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Result side: stall in windows of varying readiness; once enough traffic
    // has gone in, hold off for a long stretch so the core backs up and drops
    // s_tready while the sender keeps offering.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            rdy_next = 1'b0;
        end else if (!hold_done && sb.n_inputs >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rdy_next = 1'b0;
        end else begin
            if (win_left == 0) begin
                win_left = $urandom_range(16, 128);
                case ($urandom_range(0, 2))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    default: ready_pct = 30;
                endcase
            end
            win_left--;
            rdy_next = ($urandom_range(1, 100) <= ready_pct);
        end
        m_tready <= rdy_next;
    end

    // check every result transaction against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // watchdog: give up well past the slowest legal run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each is entered in the time step of a rising edge
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [mbsoc_pkg::CFG_IDX_W-1:0] idx,
                             logic [mbsoc_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_settings(logic [mbsoc_pkg::MODE_W-1:0] mode,
                                 logic [mbsoc_pkg::MASK_W-1:0] mask,
                                 logic [mbsoc_pkg::DEV_W-1:0] prim, logic lc_en,
                                 logic [mbsoc_pkg::MV_W-1:0] start_v,
                                 logic [mbsoc_pkg::MV_W-1:0] end_v,
                                 logic [mbsoc_pkg::SOC_W-1:0] ovr,
                                 logic [mbsoc_pkg::LOCK_W-1:0] ticks);
        write_reg(mbsoc_pkg::REG_COMBINE_MODE, mbsoc_pkg::CFG_W'(mode));
        write_reg(mbsoc_pkg::REG_SELECT_MASK, mbsoc_pkg::CFG_W'(mask));
        write_reg(mbsoc_pkg::REG_PRIMARY_INDEX, mbsoc_pkg::CFG_W'(prim));
        write_reg(mbsoc_pkg::REG_LOW_CELL_EN, mbsoc_pkg::CFG_W'(lc_en));
        write_reg(mbsoc_pkg::REG_START_MV, start_v);
        write_reg(mbsoc_pkg::REG_END_MV, end_v);
        write_reg(mbsoc_pkg::REG_OVERRIDE_SOC, mbsoc_pkg::CFG_W'(ovr));
        write_reg(mbsoc_pkg::REG_LOCK_TICKS, ticks);
        cfg_wr_en <= 1'b0;
    endtask

    // offer one transaction; open a random gap between bursts
    task automatic send_item(batt_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {{(mbsoc_pkg::S_TDATA_W - mbsoc_pkg::S_USED_W){1'b0}},
                     it.min_cell_mv, it.force_full, it.now_ms, it.soc_in, it.device};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(it);
    endtask

    // drop valid, wait out every expected result, then let any report settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic batt_item_t mk_item(logic act, logic [mbsoc_pkg::DEV_W-1:0] dev,
                                           logic [mbsoc_pkg::SOC_IN_W-1:0] soc,
                                           logic [mbsoc_pkg::TIME_W-1:0] now, logic ff,
                                           logic [mbsoc_pkg::MV_W-1:0] mv);
        batt_item_t it;
        it.action = act;
        it.device = dev;
        it.soc_in = soc;
        it.now_ms = now;
        it.force_full = ff;
        it.min_cell_mv = mv;
        return it;
    endfunction

    // cell voltage: half the time around the thresholds so the override cycles
    function automatic logic [mbsoc_pkg::MV_W-1:0] pick_mv();
        int v;
        int k;
        k = $urandom_range(0, 9);
        if (k < 3) begin
            v = int'(sb.start_mv) + int'($urandom_range(0, 2)) - 1;
        end else if (k < 5) begin
            v = (sb.end_mv != '0) ? int'(sb.end_mv) : int'(sb.start_mv);
            v = v + int'($urandom_range(0, 2)) - 1;
        end else if (k == 5) begin
            v = ($urandom_range(0, 1) == 0) ? 0 : 65535;
        end else begin
            v = int'($urandom_range(0, 65535));
        end
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[mbsoc_pkg::MV_W-1:0];
    endfunction

    // reports stamp near the running clock; computes read it exactly
    function automatic batt_item_t next_item();
        batt_item_t it;
        int r;
        int k;
        r = $urandom_range(0, 99);
        cur_ms = cur_ms + $urandom_range(0, 300);
        if (r < 2) cur_ms = cur_ms + 32'd4800 + $urandom_range(0, 400);
        else if (r == 2) cur_ms = $urandom;
        it.device = mbsoc_pkg::DEV_W'($urandom_range(0, NUM_DEV - 1));
        it.soc_in = mbsoc_pkg::SOC_IN_W'(($urandom_range(0, 4) == 0) ?
                                         $urandom_range(101, 255) :
                                         $urandom_range(0, 100));
        it.force_full = ($urandom_range(0, 11) == 0);
        it.min_cell_mv = pick_mv();
        it.now_ms = cur_ms;
        if ($urandom_range(0, 99) < 45) begin
            it.action = mbsoc_pkg::ACT_REPORT;
            k = $urandom_range(0, 19);
            if (k == 0) it.now_ms = cur_ms + $urandom_range(1, 100);
            else if (k == 1) it.now_ms = cur_ms - $urandom_range(4900, 5100);
            else it.now_ms = cur_ms - $urandom_range(0, 50);
        end else begin
            it.action = mbsoc_pkg::ACT_COMPUTE;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [mbsoc_pkg::TIME_W-1:0]  t0;
        logic [mbsoc_pkg::MODE_W-1:0]  mode_v;
        logic [mbsoc_pkg::MASK_W-1:0]  mask_v;
        logic [mbsoc_pkg::DEV_W-1:0]   prim_v;
        logic                          en_v;
        logic [mbsoc_pkg::MV_W-1:0]    start_v;
        logic [mbsoc_pkg::MV_W-1:0]    end_v;
        logic [mbsoc_pkg::SOC_W-1:0]   ovr_v;
        logic [mbsoc_pkg::LOCK_W-1:0]  lock_v;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed prologue: average of all, override clamp, short lockout
        t0 = 32'hFFFF_F000;
        load_settings(mbsoc_pkg::MODE_AVG, 8'hFF, 3'd0, 1'b1, 16'd3000, 16'd0,
                      7'd127, 16'd2);
        // nothing written yet: no fresh primary, average of nothing
        send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd0, 8'd0, t0, 1'b0, 16'hFFFF));
        send_item(mk_item(mbsoc_pkg::ACT_REPORT, 3'd0, 8'd0, t0, 1'b0, 16'h0000));
        send_item(mk_item(mbsoc_pkg::ACT_REPORT, 3'd7, 8'd255, t0, 1'b0, 16'hFFFF));
        send_item(mk_item(mbsoc_pkg::ACT_REPORT, 3'd3, 8'd101, t0 + 32'd10, 1'b1,
                          16'h0000));
        // compute past the 32-bit wrap
        send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd5, 8'd37, 32'h0000_0100, 1'b0,
                          16'hFFFF));
        // force full with a low voltage: state machine stays put
        send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd0, 8'd0, 32'h0000_0100, 1'b1,
                          16'd0));
        // enter override at the start threshold, hold, then recover above it
        send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd0, 8'd0, 32'h0000_0100, 1'b0,
                          16'd3000));
        send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd0, 8'd0, 32'h0000_0100, 1'b0,
                          16'd3000));
        send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd0, 8'd0, 32'h0000_0100, 1'b0,
                          16'd3001));
        // count the lockout down and back to waiting
        repeat (3) send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd0, 8'd0,
                                     32'h0000_0100, 1'b0, 16'd0));
        send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd0, 8'd0, 32'h0000_0100, 1'b0,
                          16'd0));
        // age exactly at the timeout is stale, one below is fresh
        send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd0, 8'd0, t0 + 32'd5000, 1'b0,
                          16'hFFFF));
        send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd0, 8'd0, t0 + 32'd4999, 1'b0,
                          16'hFFFF));
        send_item(mk_item(mbsoc_pkg::ACT_REPORT, 3'd2, 8'd255, 32'hFFFF_FFFF, 1'b0,
                          16'd0));
        send_item(mk_item(mbsoc_pkg::ACT_REPORT, 3'd4, 8'd100, 32'h0000_0000, 1'b0,
                          16'd0));
        send_item(mk_item(mbsoc_pkg::ACT_COMPUTE, 3'd0, 8'd0, 32'h0000_0000, 1'b0,
                          16'hFFFF));
        cur_ms = 32'h0000_0000;

        // random phases, each under fresh settings with the extremes spread out
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            mode_v = (p < 8) ? mbsoc_pkg::MODE_W'(p)
                             : mbsoc_pkg::MODE_W'($urandom_range(0, 4));
            case (p)
                0: mask_v = 8'h00;
                1: mask_v = 8'hFF;
                2: mask_v = 8'h80;
                default: mask_v = mbsoc_pkg::MASK_W'($urandom_range(1, 255));
            endcase
            prim_v = (p == 1) ? 3'd0 :
                     (p == 3) ? 3'd7 : mbsoc_pkg::DEV_W'($urandom_range(0, 7));
            en_v = (p % 5 != 4);
            case (p)
                5: start_v = 16'hFFFF;
                6: start_v = 16'h0000;
                default: start_v = mbsoc_pkg::MV_W'($urandom_range(2000, 4000));
            endcase
            if (p % 3 == 0) end_v = 16'd0;
            else if (p == 7 || start_v > 16'd65135) end_v = 16'hFFFF;
            else end_v = start_v + mbsoc_pkg::MV_W'($urandom_range(0, 400));
            case (p)
                2: ovr_v = 7'd127;
                3: ovr_v = 7'd100;
                6: ovr_v = 7'd0;
                default: ovr_v = mbsoc_pkg::SOC_W'($urandom_range(0, 127));
            endcase
            case (p)
                8: lock_v = 16'hFFFF;
                9: lock_v = 16'h0000;
                default: lock_v = mbsoc_pkg::LOCK_W'($urandom_range(0, 6));
            endcase
            load_settings(mode_v, mask_v, prim_v, en_v, start_v, end_v, ovr_v, lock_v);
            // move the clock close to the wrap, or somewhere arbitrary
            if (p == 3) cur_ms = 32'hFFFF_F000;
            else if (p == 6) cur_ms = $urandom;
            repeat (ITEMS_PER_PHASE) send_item(next_item());
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### multi_battery_soc_combiner_core.f
rtl/core/mbsoc_pkg.sv
rtl/core/mbsoc_table.sv
rtl/core/mbsoc_div.sv
rtl/core/multi_battery_soc_combiner_core.sv
dv/tb_multi_battery_soc_combiner_core.sv
